FILE: src/shlc_pkg.sv
// Shared types for the shell line token classifier.
// Holds the lexer mode and token class encodings and the state and result structs.
// No dependencies.
`timescale 1ns / 1ps

package shlc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STR     = 3'd1,
    MODE_STR_ESC = 3'd2,
    MODE_VAR_BEG = 3'd3,
    MODE_VAR_BRC = 3'd4,
    MODE_VAR_NAM = 3'd5,
    MODE_OP_JOIN = 3'd6,
    MODE_WORD    = 3'd7
  } lex_mode_t;

  typedef enum logic [2:0] {
    CLS_SPACE = 3'd0,
    CLS_STR   = 3'd1,
    CLS_VAR   = 3'd2,
    CLS_OP    = 3'd3,
    CLS_CMD   = 3'd4,
    CLS_ARG   = 3'd5
  } token_class_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      quote_kind;
    logic      first_pending;
  } lex_state_t;

  typedef struct packed {
    token_class_t cls;
    logic         start;
  } lex_result_t;

  localparam lex_state_t LEX_STATE_RESET = '{mode: MODE_IDLE, quote_kind: 1'b0,
                                             first_pending: 1'b1};

endpackage

FILE: src/shlc_if.sv
// Valid/ready channel interfaces for the request and result streams.
// No dependencies.
`timescale 1ns / 1ps

interface shlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output char_in, output line_end, input ready);
  modport sink (input valid, input char_in, input line_end, output ready);
endinterface

interface shlc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [2:0] token_class;
  logic       token_start;
  logic       line_done;

  modport source (output valid, output char_out, output token_class, output token_start,
                  output line_done, input ready);
  modport sink (input valid, input char_out, input token_class, input token_start,
                input line_done, output ready);
endinterface

FILE: src/shlc_lexer.sv
// Combinational lexer step: classifies one byte and computes the next lexer state.
// Depends on shlc_pkg.
`timescale 1ns / 1ps

module shlc_lexer (
  input  logic [7:0]           char_in,
  input  shlc_pkg::lex_state_t state_cur,
  output shlc_pkg::lex_state_t state_nxt,
  output shlc_pkg::lex_result_t result
);

  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  logic is_space;
  logic is_name;
  logic is_op;
  logic is_quote;
  logic closer_hit;
  logic first_eff;

  shlc_pkg::lex_state_t  idle_state;
  shlc_pkg::lex_result_t idle_result;

  always_comb begin
    is_space = (char_in == 8'h20) || (char_in >= 8'h09 && char_in <= 8'h0D);
    is_name  = (char_in >= 8'h30 && char_in <= 8'h39) ||
               (char_in >= 8'h41 && char_in <= 8'h5A) ||
               (char_in >= 8'h61 && char_in <= 8'h7A) || (char_in == CH_UNDER);
    is_op    = (char_in == CH_PIPE) || (char_in == CH_GT) || (char_in == CH_LT) ||
               (char_in == CH_AMP) || (char_in == CH_SEMI);
    is_quote = (char_in == CH_SQUOTE) || (char_in == CH_DQUOTE);
    closer_hit = state_cur.quote_kind ? (char_in == CH_DQUOTE) : (char_in == CH_SQUOTE);
  end

  // A plain word that ends clears the first-word flag before the next token starts.
  assign first_eff = (state_cur.mode == shlc_pkg::MODE_WORD) ? 1'b0 : state_cur.first_pending;

  // Classification of a byte that arrives with no token open or that closes off the open token.
  always_comb begin
    idle_state               = state_cur;
    idle_state.first_pending = first_eff;
    idle_result.start        = 1'b1;
    if (is_space) begin
      idle_result.cls   = shlc_pkg::CLS_SPACE;
      idle_result.start = 1'b0;
      idle_state.mode   = shlc_pkg::MODE_IDLE;
    end else if (is_quote) begin
      idle_result.cls          = shlc_pkg::CLS_STR;
      idle_state.quote_kind    = (char_in == CH_DQUOTE);
      idle_state.first_pending = 1'b0;
      idle_state.mode          = shlc_pkg::MODE_STR;
    end else if (char_in == CH_DOLLAR) begin
      idle_result.cls          = shlc_pkg::CLS_VAR;
      idle_state.first_pending = 1'b0;
      idle_state.mode          = shlc_pkg::MODE_VAR_BEG;
    end else if (is_op) begin
      idle_result.cls = shlc_pkg::CLS_OP;
      if (char_in == CH_GT || char_in == CH_LT || char_in == CH_AMP) begin
        idle_state.mode = shlc_pkg::MODE_OP_JOIN;
      end else begin
        idle_state.mode = shlc_pkg::MODE_IDLE;
      end
    end else begin
      idle_result.cls = first_eff ? shlc_pkg::CLS_CMD : shlc_pkg::CLS_ARG;
      idle_state.mode = shlc_pkg::MODE_WORD;
    end
  end

  always_comb begin
    state_nxt    = state_cur;
    result.cls   = shlc_pkg::CLS_SPACE;
    result.start = 1'b0;
    case (state_cur.mode)
      shlc_pkg::MODE_STR: begin
        result.cls = shlc_pkg::CLS_STR;
        if (closer_hit) begin
          state_nxt.mode = shlc_pkg::MODE_IDLE;
        end else if (char_in == CH_BSLASH) begin
          state_nxt.mode = shlc_pkg::MODE_STR_ESC;
        end
      end
      shlc_pkg::MODE_STR_ESC: begin
        result.cls     = shlc_pkg::CLS_STR;
        state_nxt.mode = shlc_pkg::MODE_STR;
      end
      shlc_pkg::MODE_VAR_BEG: begin
        if (char_in == CH_LBRACE) begin
          result.cls     = shlc_pkg::CLS_VAR;
          state_nxt.mode = shlc_pkg::MODE_VAR_BRC;
        end else if (is_name) begin
          result.cls     = shlc_pkg::CLS_VAR;
          state_nxt.mode = shlc_pkg::MODE_VAR_NAM;
        end else begin
          state_nxt = idle_state;
          result    = idle_result;
        end
      end
      shlc_pkg::MODE_VAR_BRC: begin
        result.cls = shlc_pkg::CLS_VAR;
        if (char_in == CH_RBRACE) begin
          state_nxt.mode = shlc_pkg::MODE_IDLE;
        end
      end
      shlc_pkg::MODE_VAR_NAM: begin
        if (is_name) begin
          result.cls = shlc_pkg::CLS_VAR;
        end else begin
          state_nxt = idle_state;
          result    = idle_result;
        end
      end
      shlc_pkg::MODE_OP_JOIN: begin
        if (char_in == CH_GT || char_in == CH_AMP) begin
          result.cls     = shlc_pkg::CLS_OP;
          state_nxt.mode = shlc_pkg::MODE_IDLE;
        end else begin
          state_nxt = idle_state;
          result    = idle_result;
        end
      end
      shlc_pkg::MODE_WORD: begin
        if (!is_space && !is_op && !is_quote && char_in != CH_DOLLAR) begin
          result.cls = state_cur.first_pending ? shlc_pkg::CLS_CMD : shlc_pkg::CLS_ARG;
        end else begin
          state_nxt = idle_state;
          result    = idle_result;
        end
      end
      default: begin
        state_nxt = idle_state;
        result    = idle_result;
      end
    endcase
  end

endmodule

FILE: src/shell_line_token_classifier.sv
// Shell line token classifier: an accepted request passes through the input register and then
// the result register, which offers it downstream. Throughput is one byte per cycle while the
// downstream side keeps ready high; the lexer state loop through shlc_lexer is a single register.
// Synchronous active-low reset empties both pipeline registers and returns the lexer to idle
// with the command-word flag set. A byte marked line_end also returns the lexer to that state.
// Depends on shlc_pkg, shlc_if and shlc_lexer.
`timescale 1ns / 1ps

module shell_line_token_classifier (
  input logic         clk,
  input logic         rst_n,
  shlc_in_if.sink     in_ch,
  shlc_out_if.source  out_ch
);

  // Input register: holds the accepted request until it moves into the result register.
  logic       in_vld_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // Result register: the finished result waiting for the downstream side.
  logic                    out_vld_r;
  logic [7:0]              out_char_r;
  shlc_pkg::lex_result_t   out_res_r;
  logic                    out_last_r;

  // Lexer state. It advances exactly when a request moves into the result register,
  // so each byte is classified against the state left by the byte before it.
  shlc_pkg::lex_state_t  state_r;
  shlc_pkg::lex_state_t  state_nxt;
  shlc_pkg::lex_result_t lex_res;

  logic res_free;
  logic advance;
  logic in_take;

  // The result register can load when it is empty or being drained this cycle.
  assign res_free = !out_vld_r || out_ch.ready;
  assign advance  = in_vld_r && res_free;
  // The input register takes a new request when it is empty or handing its byte on.
  assign in_take  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_vld_r || res_free;

  shlc_lexer u_lexer (
    .char_in   (in_char_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (lex_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r <= in_ch.char_in;
      in_last_r <= in_ch.line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r <= in_char_r;
      out_res_r  <= lex_res;
      out_last_r <= in_last_r;
    end
  end

  // The end of a line drops every bit of lexer state back to its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shlc_pkg::LEX_STATE_RESET;
    end else if (advance) begin
      state_r <= in_last_r ? shlc_pkg::LEX_STATE_RESET : state_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.char_out    = out_char_r;
  assign out_ch.token_class = out_res_r.cls;
  assign out_ch.token_start = out_res_r.start;
  assign out_ch.line_done   = out_last_r;

endmodule
